### hdl/bcrf_pkg.sv
package bcrf_pkg;

  localparam int SCREEN_W    = 240;
  localparam int SCREEN_H    = 240;
  localparam int BAND_ROWS   = 24;
  localparam int STORE_DEPTH = SCREEN_W * BAND_ROWS;

  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int COL_W   = $clog2(SCREEN_W + 1);
  localparam int ROW_W   = $clog2(BAND_ROWS + 1);
  localparam int CO_W    = 18;
  localparam int COUNT_W = 13;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_TOP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 1'd1;

  typedef enum logic [1:0] {
    CMD_FILL  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    JOB_NOP,
    JOB_FILL,
    JOB_READ
  } job_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FILL,
    BK_READ,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    cmd_e               command;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] span_w;
    logic signed [15:0] span_h;
    logic [15:0]        color;
  } in_word_t;

  typedef struct packed {
    logic [15:0]        read_data;
    logic               hit;
    logic [COUNT_W-1:0] pixels_written;
  } out_word_t;

  typedef struct packed {
    logic [7:0] band_top;
    logic       enabled;
  } cfg_t;

  typedef struct packed {
    cmd_e                 command;
    logic signed [CO_W-1:0] xs;
    logic signed [CO_W-1:0] xe;
    logic signed [CO_W-1:0] ys;
    logic signed [CO_W-1:0] ye;
    logic                 pos;
    logic [15:0]          color;
  } clip_t;

  typedef struct packed {
    job_kind_e        kind;
    logic [COL_W-1:0] col0;
    logic [COL_W-1:0] col1;
    logic [ROW_W-1:0] row0;
    logic [ROW_W-1:0] row1;
    logic [15:0]      color;
  } job_t;

endpackage

### hdl/bcrf_front.sv
module bcrf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bcrf_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bcrf_pkg::in_word_t in_word_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output bcrf_pkg::job_t    push_job_o
);

  localparam int CW = bcrf_pkg::CO_W;
  localparam int COL_W_L = bcrf_pkg::COL_W;
  localparam int ROW_W_L = bcrf_pkg::ROW_W;
  localparam logic signed [CW-1:0] SW_S = CW'(bcrf_pkg::SCREEN_W);
  localparam logic signed [CW-1:0] SH_S = CW'(bcrf_pkg::SCREEN_H);
  localparam logic signed [CW-1:0] BR_S = CW'(bcrf_pkg::BAND_ROWS);

  logic               s1_v_q, s2_v_q;
  bcrf_pkg::in_word_t s1_q;
  bcrf_pkg::clip_t    s2_q, clip_d;
  bcrf_pkg::job_t     job_d;
  logic               s2_load;

  assign s2_load    = s1_v_q && (!s2_v_q || push_ready_i);
  assign in_ready_o = !s1_v_q || s2_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        s1_v_q <= 1'b1;
      end else if (s2_load) begin
        s1_v_q <= 1'b0;
      end
      if (s2_load) begin
        s2_v_q <= 1'b1;
      end else if (push_ready_i) begin
        s2_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_word_i;
    end
    if (s2_load) begin
      s2_q <= clip_d;
    end
  end

  // Screen clip: start edges clamp at zero except for a read, end edges clamp at the screen size.
  always_comb begin
    logic signed [CW-1:0] x_s, y_s, w_s, h_s, xe_s, ye_s;
    x_s  = {{(CW-16){s1_q.left[15]}}, s1_q.left};
    y_s  = {{(CW-16){s1_q.top[15]}}, s1_q.top};
    w_s  = {{(CW-16){s1_q.span_w[15]}}, s1_q.span_w};
    h_s  = {{(CW-16){s1_q.span_h[15]}}, s1_q.span_h};
    xe_s = x_s + w_s;
    ye_s = y_s + h_s;
    clip_d.command = s1_q.command;
    clip_d.color   = {s1_q.color[7:0], s1_q.color[15:8]};
    clip_d.pos     = (w_s > 0) && (h_s > 0);
    clip_d.xe      = (xe_s > SW_S) ? SW_S : xe_s;
    clip_d.ye      = (ye_s > SH_S) ? SH_S : ye_s;
    if (s1_q.command == bcrf_pkg::CMD_READ) begin
      clip_d.xs = x_s;
      clip_d.ys = y_s;
    end else begin
      clip_d.xs = (x_s < 0) ? '0 : x_s;
      clip_d.ys = (y_s < 0) ? '0 : y_s;
    end
  end

  // Band clip and classification.
  always_comb begin
    logic signed [CW-1:0] bt_s, rt_s, rb_s, r0_s, r1_s;
    logic                 fill_ok, read_ok;
    bt_s    = {{(CW-8){1'b0}}, cfg_i.band_top};
    rt_s    = s2_q.ys - bt_s;
    rb_s    = s2_q.ye - bt_s;
    r0_s    = (rt_s < 0) ? '0 : rt_s;
    r1_s    = (rb_s > BR_S) ? BR_S : rb_s;
    fill_ok = s2_q.pos && (s2_q.xs < s2_q.xe) && (r0_s < r1_s);
    read_ok = (s2_q.xs >= 0) && (s2_q.xs < SW_S) && (rt_s >= 0) && (rt_s < BR_S);
    job_d.color = s2_q.color;
    job_d.col0  = s2_q.xs[COL_W_L-1:0];
    job_d.col1  = s2_q.xe[COL_W_L-1:0];
    job_d.row0  = r0_s[ROW_W_L-1:0];
    job_d.row1  = r1_s[ROW_W_L-1:0];
    job_d.kind  = bcrf_pkg::JOB_NOP;
    unique case (s2_q.command)
      bcrf_pkg::CMD_FILL: begin
        if (fill_ok) begin
          job_d.kind = bcrf_pkg::JOB_FILL;
        end
      end
      bcrf_pkg::CMD_CLEAR: begin
        job_d.kind = bcrf_pkg::JOB_FILL;
        job_d.col0 = '0;
        job_d.col1 = COL_W_L'(bcrf_pkg::SCREEN_W);
        job_d.row0 = '0;
        job_d.row1 = ROW_W_L'(bcrf_pkg::BAND_ROWS);
      end
      bcrf_pkg::CMD_READ: begin
        if (read_ok) begin
          job_d.kind = bcrf_pkg::JOB_READ;
          job_d.row0 = rt_s[ROW_W_L-1:0];
        end
      end
      default: begin
        job_d.kind = bcrf_pkg::JOB_NOP;
      end
    endcase
    if (!cfg_i.enabled) begin
      job_d.kind = bcrf_pkg::JOB_NOP;
    end
  end

  assign push_valid_o = s2_v_q;
  assign push_job_o   = job_d;

endmodule

### hdl/bcrf_queue.sv
module bcrf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  bcrf_pkg::job_t push_job_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output bcrf_pkg::job_t pop_job_o
);

  localparam int PW = bcrf_pkg::QPTR_W;
  localparam int CW = bcrf_pkg::QCNT_W;

  bcrf_pkg::job_t entry_q [bcrf_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  cnt_q;
  logic           do_push, do_pop;

  assign push_ready_o = cnt_q != CW'(bcrf_pkg::QDEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_job_o    = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(bcrf_pkg::QDEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(bcrf_pkg::QDEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= CW'(cnt_q + 1'b1);
      end else if (do_pop && !do_push) begin
        cnt_q <= CW'(cnt_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

### hdl/bcrf_back.sv
module bcrf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  bcrf_pkg::job_t      job_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bcrf_pkg::out_word_t out_word_o
);

  localparam int AW = bcrf_pkg::ADDR_W;
  localparam int CW = bcrf_pkg::COL_W;
  localparam int RW = bcrf_pkg::ROW_W;

  bcrf_pkg::back_state_e state_q, state_d;
  bcrf_pkg::job_t        job_q;
  bcrf_pkg::out_word_t   out_q;
  logic [CW-1:0]         col_q;
  logic [RW-1:0]         row_q;
  logic [AW-1:0]         base_q, addr;
  logic [bcrf_pkg::COUNT_W-1:0] count_q;
  logic [15:0]           rd_q;
  logic                  out_valid_q;
  logic                  last_col, last_row;
  logic                  pop, mem_we, mem_re, out_load;

  logic [15:0] store_mem [bcrf_pkg::STORE_DEPTH];

  assign addr     = base_q + AW'(col_q);
  assign last_col = CW'(col_q + 1'b1) == job_q.col1;
  assign last_row = RW'(row_q + 1'b1) == job_q.row1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bcrf_pkg::BK_IDLE: begin
        if (job_valid_i) begin
          unique case (job_i.kind)
            bcrf_pkg::JOB_FILL: state_d = bcrf_pkg::BK_FILL;
            bcrf_pkg::JOB_READ: state_d = bcrf_pkg::BK_READ;
            default:            state_d = bcrf_pkg::BK_DONE;
          endcase
        end
      end
      bcrf_pkg::BK_FILL: begin
        if (last_col && last_row) begin
          state_d = bcrf_pkg::BK_DONE;
        end
      end
      bcrf_pkg::BK_READ: begin
        state_d = bcrf_pkg::BK_DONE;
      end
      bcrf_pkg::BK_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = bcrf_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = bcrf_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      bcrf_pkg::BK_IDLE: pop      = job_valid_i;
      bcrf_pkg::BK_FILL: mem_we   = 1'b1;
      bcrf_pkg::BK_READ: mem_re   = 1'b1;
      bcrf_pkg::BK_DONE: out_load = !out_valid_q || out_ready_i;
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  assign job_ready_o = state_q == bcrf_pkg::BK_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bcrf_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      job_q   <= job_i;
      col_q   <= job_i.col0;
      row_q   <= job_i.row0;
      base_q  <= AW'(AW'(job_i.row0) * AW'(bcrf_pkg::SCREEN_W));
      count_q <= '0;
    end
    if (mem_we) begin
      if (count_q != bcrf_pkg::COUNT_MAX) begin
        count_q <= count_q + 1'b1;
      end
      if (last_col) begin
        col_q  <= job_q.col0;
        row_q  <= RW'(row_q + 1'b1);
        base_q <= AW'(base_q + AW'(bcrf_pkg::SCREEN_W));
      end else begin
        col_q <= CW'(col_q + 1'b1);
      end
    end
    if (out_load) begin
      out_q.read_data      <= (job_q.kind == bcrf_pkg::JOB_READ) ? rd_q : '0;
      out_q.hit            <= job_q.kind == bcrf_pkg::JOB_READ;
      out_q.pixels_written <= count_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[addr] <= job_q.color;
    end
    if (mem_re) begin
      rd_q <= store_mem[addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bcrf_pkg::BK_FILL |-> (col_q < job_q.col1) && (row_q < job_q.row1))
    else $error("fill position left the clipped rectangle");

  a_addr_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we || mem_re) |-> (32'(addr) < bcrf_pkg::STORE_DEPTH))
    else $error("store address beyond the band");

  a_read_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.hit) |-> (out_q.pixels_written == '0))
    else $error("read result reports written pixels");

  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == bcrf_pkg::BK_DONE)
    else $error("result raised outside the completion state");

endmodule

### hdl/band_clipped_rect_fill_core.sv
// Channel  Direction  Handshake                 Word
// in       input      in_valid_i / in_ready_o   in_word_i  (bcrf_pkg::in_word_t)
// out      output     out_valid_o / out_ready_i out_word_o (bcrf_pkg::out_word_t)
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// The band store has one write port, so a fill or clear writes one pixel a cycle and holds
// the back end until its last pixel is written; a clear writes SCREEN_W * BAND_ROWS pixels.
// A read passes from the idle state through the read state to the completion state, and a
// dropped command goes from the idle state straight to the completion state.
// Reset clears control state only; the band store has no reset and no clearing pass.
// A two-word queue lets the front end keep taking words while the back end or output stalls.
module band_clipped_rect_fill_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bcrf_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bcrf_pkg::out_word_t out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [bcrf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]          cfg_data_i
);

  bcrf_pkg::cfg_t cfg_q;
  bcrf_pkg::job_t push_job, pop_job;
  logic           push_valid, push_ready, pop_valid, pop_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bcrf_pkg::REG_BAND_TOP: cfg_q.band_top <= cfg_data_i;
        bcrf_pkg::REG_ENABLE:   cfg_q.enabled  <= cfg_data_i[0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  bcrf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  bcrf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  bcrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
